// ===== rtl/core/pgrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrc_pkg
// shared constants, codes and types of the polar grid range compare block
// ----------------------------------------------------------------------------
package pgrc_pkg;

  localparam int GRID_CELLS_DEF  = 65536;
  localparam int RADIUS_BITS_DEF = 20;
  localparam int ANGLE_BITS_DEF  = 16;

  localparam int INDEX_FRAC_BITS = 20;
  localparam int CPR_W           = 20;
  localparam int CELLS_W         = 17;
  localparam int TOL_W           = 20;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CPR_W-1:0]   CPR_RST     = CPR_W'(25600);
  localparam logic [CELLS_W-1:0] THETA_C_RST = CELLS_W'(64);
  localparam logic [CELLS_W-1:0] PHI_C_RST   = CELLS_W'(1024);
  localparam logic [TOL_W-1:0]   TOL_RST     = TOL_W'(128);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_COMPARE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_THETA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_PHI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPR          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THETA_CELLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_CELLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX,
    ST_CELL,
    ST_ADDR,
    ST_DATA,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic idx;
    logic stride;
  } stage_en_t;

endpackage

// ===== rtl/core/pgrc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrc_cfg_regs
// configuration register bank, written one beat at a time by index
// ----------------------------------------------------------------------------
module pgrc_cfg_regs
  import pgrc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic signed [ANGLE_BITS-1:0] origin_theta,
  output logic signed [ANGLE_BITS-1:0] origin_phi,
  output logic [CPR_W-1:0]             cells_per_radian,
  output logic [CELLS_W-1:0]           theta_cells,
  output logic [CELLS_W-1:0]           phi_cells,
  output logic [TOL_W-1:0]             range_tolerance
);

  logic signed [ANGLE_BITS-1:0] origin_theta_r;
  logic signed [ANGLE_BITS-1:0] origin_phi_r;
  logic [CPR_W-1:0]             cpr_r;
  logic [CELLS_W-1:0]           theta_cells_r;
  logic [CELLS_W-1:0]           phi_cells_r;
  logic [TOL_W-1:0]             tol_r;
  logic                         wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_theta_r <= '0;
      origin_phi_r   <= '0;
      cpr_r          <= CPR_RST;
      theta_cells_r  <= THETA_C_RST;
      phi_cells_r    <= PHI_C_RST;
      tol_r          <= TOL_RST;
    end else if (wr_en) begin
      case (cfg_index)
        REG_ORIGIN_THETA: origin_theta_r <= $signed(cfg_data[ANGLE_BITS-1:0]);
        REG_ORIGIN_PHI:   origin_phi_r   <= $signed(cfg_data[ANGLE_BITS-1:0]);
        REG_CPR:          cpr_r          <= cfg_data[CPR_W-1:0];
        REG_THETA_CELLS:  theta_cells_r  <= cfg_data[CELLS_W-1:0];
        REG_PHI_CELLS:    phi_cells_r    <= cfg_data[CELLS_W-1:0];
        REG_TOLERANCE:    tol_r          <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign origin_theta     = origin_theta_r;
  assign origin_phi       = origin_phi_r;
  assign cells_per_radian = cpr_r;
  assign theta_cells      = theta_cells_r;
  assign phi_cells        = phi_cells_r;
  assign range_tolerance  = tol_r;

endmodule

// ===== rtl/core/pgrc_cell_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrc_cell_addr
// three register stages from angles to a grid cell: axis products, axis
// indices with bounds, then row stride multiply-add
// ----------------------------------------------------------------------------
module pgrc_cell_addr
  import pgrc_pkg::*;
#(
  parameter int GRID_CELLS = GRID_CELLS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  stage_en_t                      en,
  input  logic signed [ANGLE_BITS-1:0]   in_theta,
  input  logic signed [ANGLE_BITS-1:0]   in_phi,
  input  logic signed [ANGLE_BITS-1:0]   origin_theta,
  input  logic signed [ANGLE_BITS-1:0]   origin_phi,
  input  logic [CPR_W-1:0]               cells_per_radian,
  input  logic [CELLS_W-1:0]             theta_cells,
  input  logic [CELLS_W-1:0]             phi_cells,
  output logic                           cell_in_grid,
  output logic [$clog2(GRID_CELLS)-1:0]  cell_index
);

  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int PROD_W = ANGLE_BITS + CPR_W + 2;
  localparam int IDX_W  = PROD_W - 1 - INDEX_FRAC_BITS;
  localparam int CMP_W  = (IDX_W > CELLS_W) ? IDX_W : CELLS_W;
  localparam int CW_W   = CMP_W + CELLS_W + 1;

  logic signed [ANGLE_BITS:0] dt, dp;
  logic signed [CPR_W:0]      cpr_s;
  logic signed [PROD_W-1:0]   prod_t_nxt, prod_p_nxt;
  logic signed [PROD_W-1:0]   prod_t_r, prod_p_r;
  logic [IDX_W-1:0]           it_full, ip_full;
  logic                       t_ok, p_ok;
  logic [CMP_W-1:0]           it_r, ip_r;
  logic                       axis_ok_r;
  logic [CW_W-1:0]            cell_nxt;
  logic [CW_W-1:0]            cell_r;
  logic                       cell_ok_r;

  assign dt    = {in_theta[ANGLE_BITS-1], in_theta} - {origin_theta[ANGLE_BITS-1], origin_theta};
  assign dp    = {in_phi[ANGLE_BITS-1], in_phi} - {origin_phi[ANGLE_BITS-1], origin_phi};
  assign cpr_s = $signed({1'b0, cells_per_radian});

  assign prod_t_nxt = PROD_W'(dt) * PROD_W'(cpr_s);
  assign prod_p_nxt = PROD_W'(dp) * PROD_W'(cpr_s);

  assign it_full = prod_t_r[PROD_W-2:INDEX_FRAC_BITS];
  assign ip_full = prod_p_r[PROD_W-2:INDEX_FRAC_BITS];
  assign t_ok    = !prod_t_r[PROD_W-1] && (CMP_W'(it_full) < CMP_W'(theta_cells));
  assign p_ok    = !prod_p_r[PROD_W-1] && (CMP_W'(ip_full) < CMP_W'(phi_cells));

  assign cell_nxt = CW_W'(it_r) + CW_W'(ip_r) * CW_W'(theta_cells);

  always_ff @(posedge clk) begin
    if (en.load) begin
      prod_t_r <= prod_t_nxt;
      prod_p_r <= prod_p_nxt;
    end
    if (en.idx) begin
      it_r      <= CMP_W'(it_full);
      ip_r      <= CMP_W'(ip_full);
      axis_ok_r <= t_ok & p_ok;
    end
    if (en.stride) begin
      cell_r    <= cell_nxt;
      cell_ok_r <= axis_ok_r;
    end
  end

  assign cell_in_grid = cell_ok_r && (cell_r < CW_W'(GRID_CELLS));
  assign cell_index   = cell_r[CELL_W-1:0];

endmodule

// ===== rtl/core/pgrc_grid_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrc_grid_mem
// grid store, one entry per cell: occupied flag over minimum radius,
// one write port and one registered read port
// ----------------------------------------------------------------------------
module pgrc_grid_mem
  import pgrc_pkg::*;
#(
  parameter int GRID_CELLS  = GRID_CELLS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(GRID_CELLS)-1:0] waddr,
  input  logic [RADIUS_BITS:0]          wdata,
  input  logic                          re,
  input  logic [$clog2(GRID_CELLS)-1:0] raddr,
  output logic [RADIUS_BITS:0]          rdata
);

  logic [RADIUS_BITS:0] mem [GRID_CELLS];
  logic [RADIUS_BITS:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pgrc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgrc_ctrl
// sequencer: clear walk, grid read-modify-write for inserts and the
// range compare with registered result
// ----------------------------------------------------------------------------
module pgrc_ctrl
  import pgrc_pkg::*;
#(
  parameter int GRID_CELLS  = GRID_CELLS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  input  logic [TOL_W-1:0]              range_tolerance,
  input  logic                          cell_in_grid,
  input  logic [$clog2(GRID_CELLS)-1:0] cell_index,
  output stage_en_t                     stage_en,
  output logic                          mem_we,
  output logic [$clog2(GRID_CELLS)-1:0] mem_waddr,
  output logic [RADIUS_BITS:0]          mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(GRID_CELLS)-1:0] mem_raddr,
  input  logic [RADIUS_BITS:0]          mem_rdata,
  output logic                          out_strobe,
  output logic                          out_valid_res,
  output logic signed [RADIUS_BITS:0]   out_diff,
  output logic                          out_in_grid
);

  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int DIFF_W = RADIUS_BITS + 1;
  localparam int SUM_W  = ((DIFF_W > TOL_W + 1) ? DIFF_W : TOL_W + 1) + 1;

  state_t                    state_r, state_nxt;
  logic [1:0]                cmd_r;
  logic [RADIUS_BITS-1:0]    radius_r;
  logic [CELL_W-1:0]         cell_r;
  logic                      hit_r;
  logic [CELL_W-1:0]         clr_idx_r;
  logic                      clr_last;
  logic                      accept;
  logic                      occ;
  logic [RADIUS_BITS-1:0]    rmin;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W-1:0]   margin;
  logic                      pass;
  logic                      take_new;
  logic                      out_strobe_r;
  logic                      out_valid_res_r;
  logic signed [DIFF_W-1:0]  out_diff_r;
  logic                      out_in_grid_r;

  assign accept   = start && (state_r == ST_IDLE);
  assign clr_last = (clr_idx_r == CELL_W'(GRID_CELLS - 1));

  assign occ      = mem_rdata[RADIUS_BITS];
  assign rmin     = mem_rdata[RADIUS_BITS-1:0];
  assign diff     = $signed({1'b0, rmin}) - $signed({1'b0, radius_r});
  assign margin   = SUM_W'(diff) + $signed(SUM_W'({1'b0, range_tolerance}));
  assign pass     = hit_r && occ && (rmin != '0) && !margin[SUM_W-1] && (margin != '0);
  assign take_new = hit_r && (!occ || (radius_r < rmin));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_cmd == CMD_INSERT || in_cmd == CMD_COMPARE) begin
            state_nxt = ST_IDX;
          end
        end
      end
      ST_IDX:   state_nxt = ST_CELL;
      ST_CELL:  state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_DATA;
      ST_DATA:  state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    stage_en      = '0;
    mem_we        = 1'b0;
    mem_waddr     = cell_r;
    mem_wdata     = {1'b1, radius_r};
    mem_re        = 1'b0;
    mem_raddr     = cell_index;
    case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        stage_en.load = start;
      end
      ST_IDX:  stage_en.idx    = 1'b1;
      ST_CELL: stage_en.stride = 1'b1;
      ST_ADDR: mem_re          = 1'b1;
      ST_DATA: mem_we          = (cmd_r == CMD_INSERT) && take_new;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_DATA) && (cmd_r == CMD_COMPARE);
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_last ? '0 : clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      radius_r <= in_radius;
    end
    if (state_r == ST_ADDR) begin
      hit_r  <= cell_in_grid;
      cell_r <= cell_index;
    end
    if (state_r == ST_DATA) begin
      out_valid_res_r <= pass;
      out_diff_r      <= pass ? diff : '0;
      out_in_grid_r   <= hit_r;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_valid_res = out_valid_res_r;
  assign out_diff      = out_diff_r;
  assign out_in_grid   = out_in_grid_r;

  a_valid_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_valid_res_r |-> out_in_grid_r)
    else $error("valid result outside grid");

  a_diff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_valid_res_r |-> out_diff_r == '0)
    else $error("non-zero diff on invalid result");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != ST_IDLE)
    else $error("grid write while idle");

  a_clear_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == CMD_CLEAR |=> state_r == ST_CLEAR && clr_idx_r == '0)
    else $error("clear beat did not start the walk");

  a_strobe_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_DATA) && !busy)
    else $error("result strobe without lookup");

endmodule

// ===== rtl/core/polar_grid_range_compare_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_grid_range_compare_top
// polar range image z-buffer: frame points keep the minimum radius per
// grid cell, map points are compared against their cell
//
//   channel  handshake              beat contents
//   in       start & !busy          in_cmd, in_theta, in_phi, in_radius
//   out      out_strobe (1 cycle)   out_valid_res, out_diff, out_in_grid
//   cfg      cfg_valid & cfg_ready  cfg_index, cfg_data
//
// insert and compare pass through the product, index, stride and grid
// read-modify-write stages in sequence before the next beat is accepted
// compare result strobes in the cycle after the grid read returns
// clear walks the grid one cell a cycle, busy until the last cell is written
// after reset the same clearing pass runs, busy until the last cell is written
// unused command is taken with no result and the block stays idle; out has no stall
// ----------------------------------------------------------------------------
module polar_grid_range_compare_top
  import pgrc_pkg::*;
#(
  parameter int GRID_CELLS  = GRID_CELLS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic signed [ANGLE_BITS-1:0] in_theta,
  input  logic signed [ANGLE_BITS-1:0] in_phi,
  input  logic [RADIUS_BITS-1:0]       in_radius,
  output logic                         out_strobe,
  output logic                         out_valid_res,
  output logic signed [RADIUS_BITS:0]  out_diff,
  output logic                         out_in_grid,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CELL_W = $clog2(GRID_CELLS);

  logic signed [ANGLE_BITS-1:0] origin_theta;
  logic signed [ANGLE_BITS-1:0] origin_phi;
  logic [CPR_W-1:0]             cells_per_radian;
  logic [CELLS_W-1:0]           theta_cells;
  logic [CELLS_W-1:0]           phi_cells;
  logic [TOL_W-1:0]             range_tolerance;
  stage_en_t                    stage_en;
  logic                         cell_in_grid;
  logic [CELL_W-1:0]            cell_index;
  logic                         mem_we;
  logic [CELL_W-1:0]            mem_waddr;
  logic [RADIUS_BITS:0]         mem_wdata;
  logic                         mem_re;
  logic [CELL_W-1:0]            mem_raddr;
  logic [RADIUS_BITS:0]         mem_rdata;

  pgrc_cfg_regs #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .origin_theta     (origin_theta),
    .origin_phi       (origin_phi),
    .cells_per_radian (cells_per_radian),
    .theta_cells      (theta_cells),
    .phi_cells        (phi_cells),
    .range_tolerance  (range_tolerance)
  );

  pgrc_cell_addr #(
    .GRID_CELLS (GRID_CELLS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_addr (
    .clk              (clk),
    .en               (stage_en),
    .in_theta         (in_theta),
    .in_phi           (in_phi),
    .origin_theta     (origin_theta),
    .origin_phi       (origin_phi),
    .cells_per_radian (cells_per_radian),
    .theta_cells      (theta_cells),
    .phi_cells        (phi_cells),
    .cell_in_grid     (cell_in_grid),
    .cell_index       (cell_index)
  );

  pgrc_grid_mem #(
    .GRID_CELLS  (GRID_CELLS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pgrc_ctrl #(
    .GRID_CELLS  (GRID_CELLS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_radius       (in_radius),
    .range_tolerance (range_tolerance),
    .cell_in_grid    (cell_in_grid),
    .cell_index      (cell_index),
    .stage_en        (stage_en),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .out_strobe      (out_strobe),
    .out_valid_res   (out_valid_res),
    .out_diff        (out_diff),
    .out_in_grid     (out_in_grid)
  );

endmodule

// ===== tb/sv/tb_polar_grid_range_compare_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_grid_range_compare_top
// self-checking bench for the polar grid z-buffer: a queue-fed driver pushes
// insert, compare, clear and unused beats while a shadow grid of minimum
// radii predicts every compare result; grid settings change between phases
// ----------------------------------------------------------------------------
module tb_polar_grid_range_compare_top;
  import pgrc_pkg::*;

  localparam int AW           = ANGLE_BITS_DEF;
  localparam int RW           = RADIUS_BITS_DEF;
  localparam int GRID_N       = GRID_CELLS_DEF;
  localparam int RADIUS_TOP   = (1 << RW) - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int RUN_LIMIT    = 1_500_000;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [AW-1:0] theta;
    logic [AW-1:0] phi;
    logic [RW-1:0] radius;
  } point_beat_t;

  typedef struct packed {
    logic          valid_res;
    logic [RW:0]   diff;
    logic          in_grid;
  } range_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_cmd = CMD_NONE;
  logic signed [AW-1:0]  in_theta = '0;
  logic signed [AW-1:0]  in_phi = '0;
  logic [RW-1:0]         in_radius = '0;
  logic                  out_strobe;
  logic                  out_valid_res;
  logic signed [RW:0]    out_diff;
  logic                  out_in_grid;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  polar_grid_range_compare_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_theta     (in_theta),
    .in_phi       (in_phi),
    .in_radius    (in_radius),
    .out_strobe   (out_strobe),
    .out_valid_res(out_valid_res),
    .out_diff     (out_diff),
    .out_in_grid  (out_in_grid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow grid settings and cell store
  logic signed [AW-1:0] org_theta_q = '0;
  logic signed [AW-1:0] org_phi_q = '0;
  logic [CPR_W-1:0]     cpr_q = CPR_RST;
  logic [CELLS_W-1:0]   theta_cells_q = THETA_C_RST;
  logic [CELLS_W-1:0]   phi_cells_q = PHI_C_RST;
  logic [TOL_W-1:0]     tol_q = TOL_RST;
  logic [RW-1:0]        cell_min_mirror [GRID_N];
  bit                   cell_occ_mirror [GRID_N];

  point_beat_t   pending_beats[$];
  point_beat_t   frame_points[$];
  range_result_t expected_results[$];
  point_beat_t   live_beat;

  int  issued_count = 0;
  int  accepted_count = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  mismatch_count = 0;
  int  reg_writes = 0;
  int  n_insert = 0;
  int  n_compare = 0;
  int  n_clear = 0;
  int  n_unused = 0;
  int  cycle_count = 0;
  bit  steady_feed = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit locate_cell(input logic [AW-1:0] th, input logic [AW-1:0] ph,
                                     output int unsigned cell_idx);
    longint prod_t, prod_p;
    longint unsigned it, ip, flat;
    cell_idx = 0;
    prod_t = (longint'($signed(th)) - longint'(org_theta_q)) * longint'(cpr_q);
    prod_p = (longint'($signed(ph)) - longint'(org_phi_q)) * longint'(cpr_q);
    if (prod_t < 0 || prod_p < 0) return 1'b0;
    it = longint'(prod_t) >> INDEX_FRAC_BITS;
    ip = longint'(prod_p) >> INDEX_FRAC_BITS;
    if (it >= theta_cells_q || ip >= phi_cells_q) return 1'b0;
    flat = it + longint'(theta_cells_q) * ip;
    if (flat >= GRID_N) return 1'b0;
    cell_idx = int'(flat);
    return 1'b1;
  endfunction

  function automatic void zbuffer_step(input point_beat_t b);
    int unsigned   cell_idx;
    bit            in_bounds;
    longint        gap;
    range_result_t r;
    in_bounds = locate_cell(b.theta, b.phi, cell_idx);
    case (b.cmd)
      CMD_CLEAR: begin
        foreach (cell_occ_mirror[i]) cell_occ_mirror[i] = 1'b0;
        n_clear++;
      end
      CMD_INSERT: begin
        if (in_bounds) begin
          if (!cell_occ_mirror[cell_idx] || b.radius < cell_min_mirror[cell_idx])
            cell_min_mirror[cell_idx] = b.radius;
          cell_occ_mirror[cell_idx] = 1'b1;
        end
        n_insert++;
      end
      CMD_COMPARE: begin
        r = '0;
        r.in_grid = in_bounds;
        if (in_bounds && cell_occ_mirror[cell_idx] && cell_min_mirror[cell_idx] != 0) begin
          gap = longint'(cell_min_mirror[cell_idx]) - longint'(b.radius);
          if (gap + longint'(tol_q) > 0) begin
            r.valid_res = 1'b1;
            r.diff = gap[RW:0];
          end
        end
        expected_results.insert(expected_results.size(), r);
        n_compare++;
      end
      default: n_unused++;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : feed_proc
    bit          offer_next;
    point_beat_t nb;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      offer_next = !start;
      if (start && !busy) begin
        zbuffer_step(live_beat);
        accepted_count++;
        offer_next = 1'b1;
      end
      if (offer_next) begin
        if (pending_beats.size() != 0 && (steady_feed || $urandom_range(0, 99) >= 9)) begin
          nb = pending_beats.pop_front();
          live_beat <= nb;
          start     <= 1'b1;
          in_cmd    <= nb.cmd;
          in_theta  <= nb.theta;
          in_phi    <= nb.phi;
          in_radius <= nb.radius;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on result %0d, %s: expected %0d got %0d", results_seen, what, want, got);
  endtask

  // monitor
  always @(posedge clk) begin : watch_proc
    range_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result beat with nothing pending", 0, 1);
      end else begin
        want = expected_results.pop_front();
        if (out_valid_res !== want.valid_res)
          flag_mismatch("valid_res", want.valid_res, out_valid_res);
        if (out_diff !== want.diff)
          flag_mismatch("diff", $signed(want.diff), out_diff);
        if (out_in_grid !== want.in_grid)
          flag_mismatch("in_grid", want.in_grid, out_in_grid);
        if (want.valid_res) hits_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at cycle limit, %0d beats accepted of %0d", accepted_count,
             issued_count);
    $display("tb: failure");
    $finish;
  end

  task automatic queue_beat(input logic [1:0] cmd, input int th, input int ph, input int rad);
    point_beat_t b;
    b.cmd    = cmd;
    b.theta  = th[AW-1:0];
    b.phi    = ph[AW-1:0];
    b.radius = rad[RW-1:0];
    pending_beats.insert(pending_beats.size(), b);
    issued_count++;
    if (cmd == CMD_INSERT) frame_points.insert(frame_points.size(), b);
    if (cmd == CMD_CLEAR) frame_points.delete();
  endtask

  task automatic settle();
    while (accepted_count != issued_count || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_THETA: org_theta_q = val[AW-1:0];
      REG_ORIGIN_PHI:   org_phi_q = val[AW-1:0];
      REG_CPR:          cpr_q = val[CPR_W-1:0];
      REG_THETA_CELLS:  theta_cells_q = val[CELLS_W-1:0];
      REG_PHI_CELLS:    phi_cells_q = val[CELLS_W-1:0];
      REG_TOLERANCE:    tol_q = val[TOL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_grid(input logic [31:0] ot, input logic [31:0] op, input logic [31:0] cpr,
                          input logic [31:0] tc, input logic [31:0] pc, input logic [31:0] tol);
    settle();
    write_reg(REG_ORIGIN_THETA, ot);
    write_reg(REG_ORIGIN_PHI, op);
    write_reg(REG_CPR, cpr);
    write_reg(REG_THETA_CELLS, tc);
    write_reg(REG_PHI_CELLS, pc);
    write_reg(REG_TOLERANCE, tol);
    frame_points.delete();
  endtask

  function automatic int pick_in(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_radius(input longint v);
    if (v < 0) return 0;
    if (v > RADIUS_TOP) return RADIUS_TOP;
    return int'(v);
  endfunction

  function automatic int frame_radius();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return RADIUS_TOP;
      default: return int'($urandom_range(1, RADIUS_TOP));
    endcase
  endfunction

  // radius for a map point that lands on a known frame point, biased to the tolerance edge
  function automatic int probe_radius(input logic [RW-1:0] r);
    case ($urandom_range(0, 4))
      0:       return r;
      1:       return clamp_radius(longint'(r) - longint'($urandom_range(0, 1000)));
      2:       return clamp_radius(longint'(r) + longint'(tol_q) - 1 + $urandom_range(0, 2));
      3:       return clamp_radius(longint'(r) + longint'($urandom_range(0, 2 * tol_q + 2)));
      default: return int'($urandom_range(0, RADIUS_TOP));
    endcase
  endfunction

  task automatic run_frame(input int n, input int tlo, input int thi, input int plo,
                           input int phi_top);
    int          k, roll;
    point_beat_t anchor;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (k < n / 3 || roll < 20) begin
        queue_beat(CMD_INSERT, pick_in(tlo, thi), pick_in(plo, phi_top), frame_radius());
      end else if (roll < 75 && frame_points.size() != 0) begin
        anchor = frame_points[$urandom_range(0, frame_points.size() - 1)];
        queue_beat(CMD_COMPARE, anchor.theta, anchor.phi, probe_radius(anchor.radius));
      end else if (roll < 88) begin
        queue_beat(CMD_COMPARE, pick_in(tlo, thi), pick_in(plo, phi_top),
                   int'($urandom_range(0, RADIUS_TOP)));
      end else begin
        case ($urandom_range(0, 2))
          0:       queue_beat(CMD_INSERT, $urandom, $urandom, $urandom);
          1:       queue_beat(CMD_COMPARE, $urandom, $urandom, $urandom);
          default: queue_beat(CMD_NONE, $urandom, $urandom, $urandom);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int ot, op, cpr, tc, pc;
    longint tspan, pspan;
    while (!rst_n) @(posedge clk);

    // directed: reset grid, 64 x 1024 cells at 100 cells per radian
    queue_beat(CMD_COMPARE, 100, 100, 50);
    queue_beat(CMD_INSERT, 100, 100, 1000);
    queue_beat(CMD_INSERT, 100, 100, 1200);
    queue_beat(CMD_INSERT, 100, 100, 900);
    queue_beat(CMD_COMPARE, 100, 100, 900);
    queue_beat(CMD_COMPARE, 100, 100, 1027);
    queue_beat(CMD_COMPARE, 100, 100, 1028);
    queue_beat(CMD_COMPARE, 100, 100, 0);
    queue_beat(CMD_INSERT, 200, 300, 0);
    queue_beat(CMD_COMPARE, 200, 300, 0);
    queue_beat(CMD_INSERT, -1, 100, 500);
    queue_beat(CMD_COMPARE, -1, 100, 500);
    queue_beat(CMD_INSERT, 2621, 32767, RADIUS_TOP);
    queue_beat(CMD_COMPARE, 2621, 32767, 0);
    queue_beat(CMD_COMPARE, 2622, 32767, 0);
    queue_beat(CMD_NONE, 100, 100, 7);
    queue_beat(CMD_COMPARE, -32768, -32768, RADIUS_TOP);
    queue_beat(CMD_CLEAR, 0, 0, 0);
    queue_beat(CMD_COMPARE, 100, 100, 900);

    // zero columns: nothing lands inside
    set_grid(0, 0, 25600, 0, 1024, 128);
    queue_beat(CMD_INSERT, 100, 100, 300);
    queue_beat(CMD_COMPARE, 100, 100, 300);
    // zero scale: every point folds onto the first cell
    set_grid(0, 0, 0, 64, 1024, 128);
    queue_beat(CMD_INSERT, -5, 40, 77);
    queue_beat(CMD_COMPARE, 30000, -30000, 77);
    // extreme origins, finest scale, widest tolerance
    set_grid(32767, -32768, 1048575, 65536, 1, 1048575);
    queue_beat(CMD_INSERT, 32767, 32767, 5);
    queue_beat(CMD_COMPARE, 32767, -32768, RADIUS_TOP);

    // reset grid shape, random tolerance, with a full drain half way
    set_grid(0, 0, 25600, 64, 1024, $urandom_range(0, 4095));
    run_frame(50, 0, 2700, 0, 32767);
    settle();
    run_frame(50, 0, 2700, 0, 32767);

    // coarse 64 x 64 grid covering the whole angle range, no sender gaps
    set_grid(-32768, -32768, 1024, 64, 64, 0);
    steady_feed = 1'b1;
    run_frame(90, -32768, 32767, -32768, 32767);
    settle();
    steady_feed = 1'b0;
    queue_beat(CMD_CLEAR, 0, 0, 0);
    run_frame(60, -32768, 32767, -32768, 32767);

    // one row of 65536 columns: second row spills past the store
    set_grid(0, 0, 1048575, 65536, 65536, 1048575);
    run_frame(90, 0, 32767, 0, 2);

    // random moderate grid
    ot    = -int'($urandom_range(0, 32768));
    op    = -int'($urandom_range(0, 32768));
    cpr   = $urandom_range(256, 16384);
    tc    = $urandom_range(1, 200);
    pc    = $urandom_range(1, 200);
    tspan = (longint'(tc) << INDEX_FRAC_BITS) / cpr;
    pspan = (longint'(pc) << INDEX_FRAC_BITS) / cpr;
    set_grid(ot, op, cpr, tc, pc, $urandom_range(0, 65535));
    run_frame(70, ot, int'((ot + tspan > 32767) ? 32767 : ot + tspan),
              op, int'((op + pspan > 32767) ? 32767 : op + pspan));

    // back to the reset shape with no tolerance, fresh grid
    set_grid(0, 0, 25600, 64, 1024, 0);
    queue_beat(CMD_CLEAR, 0, 0, 0);
    run_frame(60, 0, 2700, 0, 32767);

    // raw register words
    set_grid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_frame(30, -32768, 32767, -32768, 32767);

    while (accepted_count != issued_count || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d compares, %0d clears, %0d unused beats, %0d reg writes",
             n_insert, n_compare, n_clear, n_unused, reg_writes);
    $display("checked %0d result beats, %0d within tolerance, %0d mismatches", results_seen,
             hits_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pgrc_pkg.sv
rtl/core/pgrc_cfg_regs.sv
rtl/core/pgrc_cell_addr.sv
rtl/core/pgrc_grid_mem.sv
rtl/core/pgrc_ctrl.sv
rtl/core/polar_grid_range_compare_top.sv
tb/sv/tb_polar_grid_range_compare_top.sv
